[design/ntc_pkg.sv]
package ntc_pkg;

  localparam int unsigned FilterDepthDef = 8;
  localparam int unsigned TablePointsDef = 21;
  localparam int unsigned AdcW = 12;
  localparam int unsigned PullW = 17;
  localparam int unsigned ResW = 29;
  localparam int unsigned TempW = 11;
  localparam logic [AdcW-1:0] FullScale = 12'd4095;
  localparam logic [ResW-1:0] OpenOhms = 29'd999999;
  localparam logic [PullW-1:0] PullupReset = 17'd10000;

  // Table row index width; covers up to 64 rows.
  localparam int unsigned RowW = 6;

  // Descending resistance table; the 22.0 C row sits in its sorted place.
  function automatic logic [ResW-1:0] curve_ohms(input logic [RowW-1:0] idx);
    logic [ResW-1:0] v;
    unique case (idx)
      6'd0:  v = 29'd97900;
      6'd1:  v = 29'd67800;
      6'd2:  v = 29'd47600;
      6'd3:  v = 29'd33900;
      6'd4:  v = 29'd24400;
      6'd5:  v = 29'd20000;
      6'd6:  v = 29'd17400;
      6'd7:  v = 29'd12700;
      6'd8:  v = 29'd10000;
      6'd9:  v = 29'd7500;
      6'd10: v = 29'd5700;
      6'd11: v = 29'd4400;
      6'd12: v = 29'd3400;
      6'd13: v = 29'd2700;
      6'd14: v = 29'd2100;
      6'd15: v = 29'd1700;
      6'd16: v = 29'd1400;
      6'd17: v = 29'd1100;
      6'd18: v = 29'd900;
      6'd19: v = 29'd740;
      default: v = 29'd620;
    endcase
    return v;
  endfunction

  function automatic logic signed [TempW-1:0] curve_deci(input logic [RowW-1:0] idx);
    logic signed [TempW-1:0] v;
    unique case (idx)
      6'd0:  v = -11'sd100;
      6'd1:  v = 11'sd0;
      6'd2:  v = 11'sd100;
      6'd3:  v = 11'sd200;
      6'd4:  v = 11'sd220;
      6'd5:  v = 11'sd250;
      6'd6:  v = 11'sd300;
      6'd7:  v = 11'sd350;
      6'd8:  v = 11'sd400;
      6'd9:  v = 11'sd450;
      6'd10: v = 11'sd500;
      6'd11: v = 11'sd550;
      6'd12: v = 11'sd600;
      6'd13: v = 11'sd650;
      6'd14: v = 11'sd700;
      6'd15: v = 11'sd750;
      6'd16: v = 11'sd800;
      6'd17: v = 11'sd850;
      6'd18: v = 11'sd900;
      6'd19: v = 11'sd950;
      default: v = 11'sd1000;
    endcase
    return v;
  endfunction

  // Request to the shared bit-serial divider.
  typedef struct packed {
    logic        start;
    logic [45:0] dividend;
    logic [28:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [45:0] quotient;
  } div_rsp_t;

endpackage

[design/ntc_divider.sv]
// Restoring divider that retires one quotient bit per cycle.
module ntc_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  ntc_pkg::div_req_t req,
  output ntc_pkg::div_rsp_t rsp
);

  localparam int unsigned NumW = 46;
  localparam int unsigned DenW = 29;

  logic [NumW-1:0] quo_r;
  logic [DenW:0]   rem_r;
  logic [DenW-1:0] den_r;
  logic [5:0]      cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  assign trial = {rem_r[DenW-1:0], quo_r[NumW-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(NumW);
        quo_r  <= req.dividend;
        den_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        if (!diff[DenW]) begin
          rem_r <= diff;
          quo_r <= {quo_r[NumW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[NumW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[design/ntc_multiplier.sv]
// Shift-and-add multiplier, one multiplier bit per cycle.
module ntc_multiplier #(
  parameter int unsigned AW = 17,
  parameter int unsigned BW = 29
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] product
);

  localparam int unsigned CntW = $clog2(AW + 1);

  logic [AW-1:0]    a_r;
  logic [AW+BW-1:0] b_r;
  logic [AW+BW-1:0] acc_r;
  logic [CntW-1:0]  cnt_r;
  logic             busy_r;
  logic             done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        a_r    <= a;
        b_r    <= (AW+BW)'(b);
        acc_r  <= '0;
        cnt_r  <= CntW'(AW);
      end else if (busy_r) begin
        if (a_r[0]) begin
          acc_r <= acc_r + b_r;
        end
        a_r   <= a_r >> 1;
        b_r   <= b_r << 1;
        cnt_r <= cnt_r - CntW'(1);
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

[design/ntc_thermistor_temperature_top.sv]
// NTC thermistor temperature converter.
// Input channel (in_*): one word per ADC sample, 16 bits in in_tdata. The sample
// is clamped to full scale and stored in a ring of the last FILTER_DEPTH samples.
// Output channel (out_*): one word per sample carrying the clamped sample, the
// truncated mean, the thermistor resistance, the temperature in tenths of a
// degree and the open- and short-circuit flags.
// Configuration (cfg_*): APB-style port; register 0 at address 0 is the pull-up
// resistance in ohms, reset 10000.
// The bit-serial divider is used up to three times per word: for the mean, the
// divider equation and the interpolation. The bit-serial multiplier forms the
// pull-up product and the interpolation slope, and the table is scanned one row
// per cycle. Open and short circuits skip the resistance and interpolation
// arithmetic. A new word is taken once the previous result has been handed to
// the output register. After reset the ring is empty, the mean counts only
// written samples, and the pull-up returns to 10000 ohms. While the receiver
// stalls, the result holds in the output register and at most one further word
// enters the converter.
module ntc_thermistor_temperature_top #(
  parameter int unsigned FILTER_DEPTH = ntc_pkg::FilterDepthDef,
  parameter int unsigned TABLE_POINTS = ntc_pkg::TablePointsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] adc_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  // [11:0] latest_raw, [23:12] filtered_adc, [52:24] resistance_ohm,
  // [63:53] temp_deci_c, [64] open_circuit, [65] short_circuit, [71:66] zero
  output logic [71:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned IdxW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FILTER_DEPTH + 1);
  localparam int unsigned SumW = ntc_pkg::AdcW + $clog2(FILTER_DEPTH + 1);
  localparam int unsigned AdcW = ntc_pkg::AdcW;
  localparam int unsigned ResW = ntc_pkg::ResW;
  localparam int unsigned TempW = ntc_pkg::TempW;
  localparam int unsigned RowW = ntc_pkg::RowW;
  localparam logic [1:0] RegPullup = 2'd0;

  typedef enum logic [3:0] {
    S_IDLE, S_RING_RD, S_SUM, S_MEAN, S_MUL, S_RDIV, S_SCAN, S_IMUL, S_IDIV, S_OUT
  } state_t;

  state_t state_r;

  // Configuration register.
  logic [ntc_pkg::PullW-1:0] pullup_r;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pullup_r <= ntc_pkg::PullupReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == RegPullup) begin
      pullup_r <= cfg_pwdata[ntc_pkg::PullW-1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr == RegPullup) ? 32'(pullup_r) : 32'd0;

  // Sample ring.
  logic [AdcW-1:0] ring_mem [FILTER_DEPTH];
  logic [AdcW-1:0] ring_q_r;
  logic [IdxW-1:0] widx_r;
  logic            full_r;
  logic [SumW-1:0] sum_r;

  logic [AdcW-1:0] raw_r;
  logic [AdcW-1:0] filt_r;
  logic [ResW-1:0] res_r;
  logic signed [TempW-1:0] temp_r;
  logic [RowW-1:0] row_r;

  // Shared arithmetic units.
  ntc_pkg::div_req_t div_req;
  ntc_pkg::div_rsp_t div_rsp;
  logic              mul_start;
  logic [16:0]       mul_a;
  logic [28:0]       mul_b;
  logic              mul_done;
  logic [45:0]       mul_p;

  ntc_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  ntc_multiplier #(.AW(17), .BW(29)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .product(mul_p)
  );

  logic [CntW-1:0] count_now;
  logic [AdcW-1:0] in_raw;
  logic [ResW-1:0] rh, rl;
  logic signed [TempW-1:0] th, tl;
  logic [TempW-1:0] dt;
  logic [RowW-1:0] row_nxt;
  logic            scan_hi;
  logic            scan_lo;
  logic            mean_mid;
  logic            div_go;
  logic            mul_go;
  logic            out_set;

  assign in_raw = (in_tdata > 16'(ntc_pkg::FullScale)) ? ntc_pkg::FullScale
                                                       : in_tdata[AdcW-1:0];
  assign row_nxt = row_r + RowW'(1);
  assign rh = ntc_pkg::curve_ohms(row_r);
  assign rl = ntc_pkg::curve_ohms(row_nxt);
  assign th = ntc_pkg::curve_deci(row_r);
  assign tl = ntc_pkg::curve_deci(row_nxt);
  assign dt = TempW'(tl - th);
  assign count_now = full_r ? CntW'(FILTER_DEPTH) : CntW'(widx_r);

  // Clamp tests against both table ends.
  assign scan_hi = (res_r >= ntc_pkg::curve_ohms('0));
  assign scan_lo = (res_r <= ntc_pkg::curve_ohms(RowW'(TABLE_POINTS - 1)));
  assign mean_mid = (div_rsp.quotient[AdcW-1:0] != '0) &&
                    (div_rsp.quotient[AdcW-1:0] != ntc_pkg::FullScale);

  // One-cycle start pulses for the shared units.
  assign div_go = (state_r == S_SUM) ||
                  ((state_r == S_MUL || state_r == S_IMUL) && mul_done);
  assign mul_go = (state_r == S_MEAN && div_rsp.done && mean_mid) ||
                  (state_r == S_SCAN && !scan_hi && !scan_lo && res_r >= rl &&
                   rh != rl);
  assign out_set = (state_r == S_OUT) && (!out_tvalid || out_tready);

  assign in_tready = rst_n && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ring_q_r <= ring_mem[widx_r];
      ring_mem[widx_r] <= in_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      widx_r     <= '0;
      full_r     <= 1'b0;
      sum_r      <= '0;
      out_tvalid <= 1'b0;
      div_req    <= '0;
      mul_start  <= 1'b0;
    end else begin
      div_req.start <= div_go;
      mul_start     <= mul_go;
      out_tvalid    <= out_set || (out_tvalid && !out_tready);
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            raw_r   <= in_raw;
            state_r <= S_RING_RD;
          end
        end
        S_RING_RD: begin
          // Old entry is now registered; drop it when the ring has wrapped.
          if (full_r) begin
            sum_r <= sum_r - SumW'(ring_q_r) + SumW'(raw_r);
          end else begin
            sum_r <= sum_r + SumW'(raw_r);
          end
          if (widx_r == IdxW'(FILTER_DEPTH - 1)) begin
            widx_r <= '0;
            full_r <= 1'b1;
          end else begin
            widx_r <= widx_r + IdxW'(1);
          end
          state_r <= S_SUM;
        end
        S_SUM: begin
          div_req.dividend <= 46'(sum_r);
          div_req.divisor  <= 29'(count_now);
          state_r          <= S_MEAN;
        end
        S_MEAN: begin
          if (div_rsp.done) begin
            filt_r <= div_rsp.quotient[AdcW-1:0];
            if (div_rsp.quotient[AdcW-1:0] == '0) begin
              res_r   <= ntc_pkg::OpenOhms;
              row_r   <= '0;
              state_r <= S_SCAN;
            end else if (div_rsp.quotient[AdcW-1:0] == ntc_pkg::FullScale) begin
              res_r   <= '0;
              row_r   <= '0;
              state_r <= S_SCAN;
            end else begin
              mul_a     <= pullup_r;
              mul_b     <= 29'(div_rsp.quotient[AdcW-1:0]);
              state_r   <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            div_req.dividend <= mul_p;
            div_req.divisor  <= 29'(ntc_pkg::FullScale - filt_r);
            state_r          <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (div_rsp.done) begin
            res_r   <= div_rsp.quotient[ResW-1:0];
            row_r   <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // One table row per cycle; clamps at both ends.
          if (scan_hi) begin
            temp_r  <= ntc_pkg::curve_deci('0);
            state_r <= S_OUT;
          end else if (scan_lo) begin
            temp_r  <= ntc_pkg::curve_deci(RowW'(TABLE_POINTS - 1));
            state_r <= S_OUT;
          end else if (res_r >= rl) begin
            if (rh == rl) begin
              temp_r  <= th;
              state_r <= S_OUT;
            end else begin
              // Slope is positive as the table descends.
              mul_a     <= 17'(dt);
              mul_b     <= rh - res_r;
              state_r   <= S_IMUL;
            end
          end else begin
            row_r <= row_nxt;
          end
        end
        S_IMUL: begin
          if (mul_done) begin
            div_req.dividend <= mul_p;
            div_req.divisor  <= rh - rl;
            state_r          <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (div_rsp.done) begin
            temp_r  <= th + TempW'(div_rsp.quotient[TempW-1:0]);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_set) begin
            out_tdata  <= {6'd0, filt_r == ntc_pkg::FullScale, filt_r == '0,
                           temp_r, res_r, filt_r, raw_r};
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[design/ntc_checker.sv]
module ntc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed under stall");

  // The flags never both set.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[64] && out_tdata[65]))
    else $error("open and short both flagged");

  // Open circuit reports a zero mean.
  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64] |-> out_tdata[23:12] == 12'd0)
    else $error("open flag without zero mean");

  // An accepted word cannot produce a result in the very next cycle.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

endmodule

bind ntc_thermistor_temperature_top ntc_checker u_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
